@@ hdl/cmpt_pkg.sv @@
// shared types and constants for the compact target codec
`timescale 1ns / 1ps
`default_nettype none

package cmpt_pkg;

   // field widths
   localparam int COMPACT_W = 32;
   localparam int WORD_W    = 64;
   localparam int VALUE_W   = 4 * WORD_W;
   localparam int MANT_W    = 23;
   localparam int EXP_W     = 8;

   // compact word layout
   localparam int SIGN_POS  = 23;
   localparam int EXP_LSB   = 24;

   // request kinds
   localparam logic REQ_DECODE = 1'b0;
   localparam logic REQ_ENCODE = 1'b1;

   typedef logic [VALUE_W-1:0] value_type;

   // one input item
   typedef struct packed {
      logic                 req_type;
      logic [COMPACT_W-1:0] compact;
      logic [WORD_W-1:0]    value_w0;
      logic [WORD_W-1:0]    value_w1;
      logic [WORD_W-1:0]    value_w2;
      logic [WORD_W-1:0]    value_w3;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [COMPACT_W-1:0] normal_compact;
      logic                 overflow;
      logic [WORD_W-1:0]    target_w0;
      logic [WORD_W-1:0]    target_w1;
      logic [WORD_W-1:0]    target_w2;
      logic [WORD_W-1:0]    target_w3;
   } rsp_item_type;

   // expanded value handed from the expander to the normalizer and result stage
   typedef struct packed {
      value_type value;
      logic      overflow;
   } expand_type;

endpackage

`default_nettype wire

@@ hdl/cmpt_expand.sv @@
// expands a compact word into a 256-bit value, or passes an encode value through
`timescale 1ns / 1ps
`default_nettype none

module cmpt_expand (
   input  wire cmpt_pkg::req_item_type item,
   output cmpt_pkg::expand_type        result
);
   import cmpt_pkg::*;

   logic [MANT_W-1:0] mant;
   logic [EXP_W-1:0]  exp_val;
   logic [EXP_W-1:0]  exp_off;
   logic [1:0]        mant_bytes;
   logic              too_large;
   value_type         mant_ext;
   value_type         shifted;

   // split the compact word
   assign mant     = item.compact[MANT_W-1:0];
   assign exp_val  = item.compact[COMPACT_W-1:EXP_LSB];
   assign exp_off  = exp_val - EXP_W'(3);
   assign mant_ext = {(VALUE_W-MANT_W)'(0), mant};

   // byte length of the mantissa
   always_comb begin
      priority if (mant > MANT_W'(16'hffff)) begin
         mant_bytes = 2'd3;
      end else if (mant > MANT_W'(8'hff)) begin
         mant_bytes = 2'd2;
      end else if (mant != '0) begin
         mant_bytes = 2'd1;
      end else begin
         mant_bytes = 2'd0;
      end
   end

   // value would pass 256 bits
   assign too_large = (mant != '0) &&
                      (({1'b0, exp_val} + {7'b0, mant_bytes}) > 9'd35);

   // left byte shift; in range it never exceeds 31 bytes
   assign shifted = mant_ext << {exp_off[4:0], 3'b000};

   // select the value
   always_comb begin
      result.value    = '0;
      result.overflow = 1'b0;
      priority if (item.req_type == REQ_ENCODE) begin
         result.value = {item.value_w3, item.value_w2, item.value_w1, item.value_w0};
      end else if (item.compact[SIGN_POS]) begin
         result.value = '0;
      end else if (exp_val <= EXP_W'(3)) begin
         unique case (exp_val[1:0])
            2'd0:    result.value = mant_ext >> 24;
            2'd1:    result.value = mant_ext >> 16;
            2'd2:    result.value = mant_ext >> 8;
            default: result.value = mant_ext;
         endcase
      end else if (too_large) begin
         result.overflow = 1'b1;
      end else begin
         result.value = shifted;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cmpt_normalize.sv @@
// builds the canonical compact word of a 256-bit value
`timescale 1ns / 1ps
`default_nettype none

module cmpt_normalize (
   input  wire cmpt_pkg::value_type       value,
   output logic [cmpt_pkg::COMPACT_W-1:0] compact
);
   import cmpt_pkg::*;

   localparam int EXT_W = VALUE_W + 24;

   logic [5:0]       num_bytes;
   logic [EXT_W-1:0] value_ext;
   logic [EXT_W-1:0] window;
   logic [23:0]      mant;
   logic [EXP_W-1:0] exp_val;
   logic [23:0]      mant_out;

   // byte length from the highest nonzero byte
   always_comb begin
      num_bytes = '0;
      for (int i = 0; i < VALUE_W / 8; i++) begin
         if (|value[8*i +: 8]) begin
            num_bytes = 6'(i + 1);
         end
      end
   end

   // top three bytes, zero padded below the value
   assign value_ext = {value, 24'b0};
   assign window    = value_ext >> {num_bytes, 3'b000};
   assign mant      = window[23:0];

   // keep the sign bit clear by moving one byte into the exponent
   always_comb begin
      if (mant[SIGN_POS]) begin
         exp_val  = {2'b00, num_bytes} + EXP_W'(1);
         mant_out = {8'b0, mant[23:8]};
      end else begin
         exp_val  = {2'b00, num_bytes};
         mant_out = mant;
      end
   end

   assign compact = {exp_val, mant_out};

endmodule

`default_nettype wire

@@ hdl/compact_target_codec.sv @@
// compact target codec top level: input register, conversion, result register
//
//   channel   ports                     handshake
//   request   start, busy, req_item     taken when start is high and busy is low
//   result    rsp_valid, rsp_item       one cycle strobe, cannot be held off
//
// one item per cycle while busy is low; a taken item is held in the input register, then its
// result in the result register, around the single conversion pass
// busy is raised by reset and cleared by the busy register once reset is low, then stays low
// synchronous active high reset clears the valid flags and raises busy
// the receiver cannot stall, so nothing backs up
`timescale 1ns / 1ps
`default_nettype none

module compact_target_codec (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire cmpt_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   output cmpt_pkg::rsp_item_type      rsp_item
);
   import cmpt_pkg::*;

   logic         busy_ff;
   logic         busy_in;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   expand_type   expanded;
   logic [COMPACT_W-1:0] norm_compact;

   // conversion datapath
   cmpt_expand u_expand (
      .item   (in_item_ff),
      .result (expanded)
   );

   cmpt_normalize u_normalize (
      .value   (expanded.value),
      .compact (norm_compact)
   );

   // next values
   assign busy_in      = 1'b0;
   assign in_valid_in  = start && !busy_ff;
   assign rsp_valid_in = in_valid_ff;

   always_comb begin
      rsp_item_in.normal_compact = norm_compact;
      rsp_item_in.overflow       = expanded.overflow;
      rsp_item_in.target_w0      = expanded.value[0*WORD_W +: WORD_W];
      rsp_item_in.target_w1      = expanded.value[1*WORD_W +: WORD_W];
      rsp_item_in.target_w2      = expanded.value[2*WORD_W +: WORD_W];
      rsp_item_in.target_w3      = expanded.value[3*WORD_W +: WORD_W];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_item_ff <= req_item;
      end
      if (rsp_valid_in) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // every item held in the input register gives a result on the next cycle
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> rsp_valid_ff)
      else $error("taken item produced no result");

   // overflow leaves a zero target and zero compact word
   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.overflow) |->
         (rsp_item_ff.target_w0 == '0 && rsp_item_ff.target_w1 == '0 &&
          rsp_item_ff.target_w2 == '0 && rsp_item_ff.target_w3 == '0 &&
          rsp_item_ff.normal_compact == '0))
      else $error("overflow with nonzero target");

   // renormalized word never carries the sign bit
   a_sign_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_item_ff.normal_compact[SIGN_POS])
      else $error("sign bit set in normalized compact word");

   // only a decode can overflow
   a_overflow_decode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.overflow) |-> $past(in_item_ff.req_type == REQ_DECODE))
      else $error("overflow flagged for an encode item");
`endif

endmodule

`default_nettype wire
